[src/dda_pkg.sv]
// Shared constants and controller/datapath interface types for the grid ray walker.
`default_nettype none
package dda_pkg;

	localparam int MAP_DIM    = 64;
	localparam int IDX_W      = $clog2(MAP_DIM);
	localparam int BND_W      = IDX_W + 1;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = 22;
	localparam int DELTA_W    = 32;
	localparam int SIDE_W     = 40;
	localparam int CODE_W     = 8;
	localparam int PART_W     = FRAC_BITS + 1;
	localparam int PROD_W     = PART_W + DELTA_W;
	localparam int STEP_LIMIT = 2 * MAP_DIM + 2;
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CODE_W-1:0] CODE_WALL = 8'h31;
	localparam logic [CODE_W-1:0] CODE_DOOR = 8'h44;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'b1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_RAY   = 1'b1;

	typedef struct packed {
		logic write;    // store one map cell
		logic load;     // take a ray and set up its walk
		logic step;     // advance one cell along the smaller side distance
		logic capture;  // latch the code of the cell just entered
	} dda_cmd_t;

	typedef struct packed {
		logic esc;      // walk has left the bounds (or started outside)
		logic oob;      // the pending step would leave the bounds
		logic hit;      // cell just read is a wall or a door
		logic limit;    // step budget used up
	} dda_status_t;

endpackage
`default_nettype wire

[src/dda_ctrl.sv]
// Sequencing state machine for the grid ray walker.
`default_nettype none
module dda_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 req_type,
	input  wire dda_pkg::dda_status_t st,
	output dda_pkg::dda_cmd_t         cmd,
	output logic                      busy,
	output logic                      done
);
	import dda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   take;

	assign take = start && !busy_q;

	always_comb begin
		cmd         = '0;
		cmd.write   = take && (req_type == REQ_WRITE);
		cmd.load    = take && (req_type == REQ_RAY);
		cmd.step    = (state_q == ST_STEP) && !st.esc;
		cmd.capture = (state_q == ST_CHECK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_STEP;
						busy_q  <= 1'b1;
					end
				end
				ST_STEP: begin
					if (st.esc || st.oob) begin
						state_q <= ST_DONE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (st.hit || st.limit) begin
						state_q <= ST_DONE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire

[src/dda_datapath.sv]
// Map store, bounds registers, side distance setup and per-cell step logic.
`default_nettype none
module dda_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dda_pkg::dda_cmd_t                    cmd,
	output dda_pkg::dda_status_t                      st,
	input  wire logic                                 cfg_we,
	input  wire logic [dda_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dda_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic [dda_pkg::IDX_W-1:0]            cell_col,
	input  wire logic [dda_pkg::IDX_W-1:0]            cell_row,
	input  wire logic [dda_pkg::CODE_W-1:0]           cell_code,
	input  wire logic [dda_pkg::POS_W-1:0]            start_x,
	input  wire logic [dda_pkg::POS_W-1:0]            start_y,
	input  wire logic                                 dir_x_negative,
	input  wire logic                                 dir_y_negative,
	input  wire logic [dda_pkg::DELTA_W-1:0]          delta_x,
	input  wire logic [dda_pkg::DELTA_W-1:0]          delta_y,
	output logic      [dda_pkg::IDX_W-1:0]            hit_col,
	output logic      [dda_pkg::IDX_W-1:0]            hit_row,
	output logic                                      hit_side,
	output logic      [dda_pkg::SIDE_W-1:0]           final_side_x,
	output logic      [dda_pkg::SIDE_W-1:0]           final_side_y,
	output logic      [dda_pkg::CODE_W-1:0]           hit_code,
	output logic                                      escaped
);
	import dda_pkg::*;

	logic [CODE_W-1:0] map_mem [MAP_DEPTH];
	logic [CODE_W-1:0] rd_code_q;

	logic [CFG_W-1:0]   cols_q, rows_q;
	logic [BND_W-1:0]   bnd_col, bnd_row;

	logic [IDX_W-1:0]   col_q, row_q;
	logic [SIDE_W-1:0]  sx_q, sy_q;
	logic [DELTA_W-1:0] dx_q, dy_q;
	logic               dxn_q, dyn_q;
	logic               side_q, esc_q;
	logic [CODE_W-1:0]  code_q;
	logic [STEP_W-1:0]  steps_q;

	logic [PART_W-1:0]  part_x, part_y;
	logic [PROD_W-1:0]  prod_x, prod_y;
	logic [IDX_W-1:0]   start_col, start_row;
	logic               start_oob;

	logic               take_x, oob_x, oob_y, oob;
	logic [SIDE_W:0]    sum_x, sum_y;
	logic [SIDE_W-1:0]  sat_x, sat_y;
	logic [BND_W-1:0]   col_inc, row_inc;
	logic [IDX_W-1:0]   nxt_col, nxt_row;

	// bounds are min(register, MAP_DIM)
	assign bnd_col = (BND_W'(cols_q) > BND_W'(MAP_DIM)) ? BND_W'(MAP_DIM) : BND_W'(cols_q);
	assign bnd_row = (BND_W'(rows_q) > BND_W'(MAP_DIM)) ? BND_W'(MAP_DIM) : BND_W'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_W'(MAP_DIM);
			rows_q <= CFG_W'(MAP_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_COLS: cols_q <= cfg_data;
				REG_MAP_ROWS: rows_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// initial side distance: fraction (or 1 - fraction) times delta, truncated
	assign part_x = dir_x_negative ? {1'b0, start_x[FRAC_BITS-1:0]}
	                               : PART_W'(1 << FRAC_BITS) - {1'b0, start_x[FRAC_BITS-1:0]};
	assign part_y = dir_y_negative ? {1'b0, start_y[FRAC_BITS-1:0]}
	                               : PART_W'(1 << FRAC_BITS) - {1'b0, start_y[FRAC_BITS-1:0]};
	assign prod_x = PROD_W'(part_x) * PROD_W'(delta_x);
	assign prod_y = PROD_W'(part_y) * PROD_W'(delta_y);

	assign start_col = start_x[FRAC_BITS +: IDX_W];
	assign start_row = start_y[FRAC_BITS +: IDX_W];
	assign start_oob = (BND_W'(start_col) >= bnd_col) || (BND_W'(start_row) >= bnd_row);

	// step decision; a tie steps in y
	assign take_x  = sx_q < sy_q;
	assign sum_x   = {1'b0, sx_q} + (SIDE_W+1)'(dx_q);
	assign sum_y   = {1'b0, sy_q} + (SIDE_W+1)'(dy_q);
	assign sat_x   = sum_x[SIDE_W] ? '1 : sum_x[SIDE_W-1:0];
	assign sat_y   = sum_y[SIDE_W] ? '1 : sum_y[SIDE_W-1:0];
	assign col_inc = BND_W'(col_q) + BND_W'(1);
	assign row_inc = BND_W'(row_q) + BND_W'(1);
	assign oob_x   = dxn_q ? (col_q == '0) : (col_inc >= bnd_col);
	assign oob_y   = dyn_q ? (row_q == '0) : (row_inc >= bnd_row);
	assign oob     = take_x ? oob_x : oob_y;

	always_comb begin
		nxt_col = col_q;
		nxt_row = row_q;
		if (take_x && !oob_x) begin
			nxt_col = dxn_q ? col_q - IDX_W'(1) : col_q + IDX_W'(1);
		end else if (!take_x && !oob_y) begin
			nxt_row = dyn_q ? row_q - IDX_W'(1) : row_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			steps_q <= '0;
		end else if (cmd.load) begin
			esc_q   <= start_oob;
			steps_q <= '0;
		end else if (cmd.step) begin
			if (oob) begin
				esc_q <= 1'b1;
			end else begin
				steps_q <= steps_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q  <= start_col;
			row_q  <= start_row;
			sx_q   <= SIDE_W'(prod_x[PROD_W-1:FRAC_BITS]);
			sy_q   <= SIDE_W'(prod_y[PROD_W-1:FRAC_BITS]);
			dx_q   <= delta_x;
			dy_q   <= delta_y;
			dxn_q  <= dir_x_negative;
			dyn_q  <= dir_y_negative;
			side_q <= 1'b0;
			code_q <= '0;
		end else if (cmd.step) begin
			col_q  <= nxt_col;
			row_q  <= nxt_row;
			side_q <= !take_x;
			if (take_x) begin
				sx_q <= sat_x;
			end else begin
				sy_q <= sat_y;
			end
		end else if (cmd.capture) begin
			code_q <= rd_code_q;
		end
	end

	// map store: one write port, one registered read at the cell being entered
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			map_mem[{cell_row, cell_col}] <= cell_code;
		end
		rd_code_q <= map_mem[{nxt_row, nxt_col}];
	end

	assign st.esc   = esc_q;
	assign st.oob   = oob;
	assign st.hit   = (rd_code_q == CODE_WALL) || (rd_code_q == CODE_DOOR);
	assign st.limit = (steps_q == STEP_W'(STEP_LIMIT));

	assign hit_col      = col_q;
	assign hit_row      = row_q;
	assign hit_side     = side_q;
	assign final_side_x = sx_q;
	assign final_side_y = sy_q;
	assign hit_code     = esc_q ? '0 : code_q;
	assign escaped      = esc_q;

endmodule
`default_nettype wire

[src/dda_ray_grid_walk.sv]
// Grid ray walker: 64x64 map of cell codes stepped cell by cell along a ray.
// Map write: no result; busy stays low, so writes may come every cycle while no walk is busy.
// Ray: for each cell entered the walk passes a step state and a check state that reads the map,
// plus one more step state when the walk leaves the bounds; done then follows.
// The next request is taken in the cycle after done.
// Results stay until the next ray is taken; done marks them for one cycle. arst_n clears control and bounds
// (64x64); map contents are undefined until written.
`default_nettype none
module dda_ray_grid_walk (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic                                 req_type,
	input  wire logic [dda_pkg::IDX_W-1:0]            cell_col,
	input  wire logic [dda_pkg::IDX_W-1:0]            cell_row,
	input  wire logic [dda_pkg::CODE_W-1:0]           cell_code,
	input  wire logic [dda_pkg::POS_W-1:0]            start_x,
	input  wire logic [dda_pkg::POS_W-1:0]            start_y,
	input  wire logic                                 dir_x_negative,
	input  wire logic                                 dir_y_negative,
	input  wire logic [dda_pkg::DELTA_W-1:0]          delta_x,
	input  wire logic [dda_pkg::DELTA_W-1:0]          delta_y,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dda_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dda_pkg::CFG_W-1:0]            cfg_data,
	output logic                                      done,
	output logic      [dda_pkg::IDX_W-1:0]            hit_col,
	output logic      [dda_pkg::IDX_W-1:0]            hit_row,
	output logic                                      hit_side,
	output logic      [dda_pkg::SIDE_W-1:0]           final_side_x,
	output logic      [dda_pkg::SIDE_W-1:0]           final_side_y,
	output logic      [dda_pkg::CODE_W-1:0]           hit_code,
	output logic                                      escaped
);
	import dda_pkg::*;

	dda_cmd_t    cmd;
	dda_status_t st;

	assign cfg_ready = 1'b1;

	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	dda_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cell_col       (cell_col),
		.cell_row       (cell_row),
		.cell_code      (cell_code),
		.start_x        (start_x),
		.start_y        (start_y),
		.dir_x_negative (dir_x_negative),
		.dir_y_negative (dir_y_negative),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.hit_col        (hit_col),
		.hit_row        (hit_row),
		.hit_side       (hit_side),
		.final_side_x   (final_side_x),
		.final_side_y   (final_side_y),
		.hit_code       (hit_code),
		.escaped        (escaped)
	);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a walk");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_ends_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("walk ended without a result");

	a_escape_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && escaped) |-> (hit_code == '0))
		else $error("escaped walk reports a cell code");

endmodule
`default_nettype wire
